@@ rtl/box_downscale_planar_normalizer_assert.svh @@
// Assertion macros used by the checker file of the downscaler.
`ifndef BOX_DOWNSCALE_PLANAR_NORMALIZER_ASSERT_SVH
`define BOX_DOWNSCALE_PLANAR_NORMALIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDPN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("downscaler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDPN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("downscaler check failed");

`endif

@@ rtl/bdpn_pkg.sv @@
// Shared types, constants and helpers of the box downscaler.
package bdpn_pkg;

	localparam int MAX_OUT_WIDTH = 1024;
	localparam int ADDR_W        = $clog2(MAX_OUT_WIDTH);
	localparam int WIDTH_CAP     = (MAX_OUT_WIDTH < 1024) ? MAX_OUT_WIDTH : 1024;
	localparam int HEIGHT_CAP    = 1024;
	localparam int CFG_W         = 11;
	localparam int DIM2_W        = CFG_W + 1;
	localparam int CFG_IDX_W     = 2;
	localparam int QUEUE_DEPTH   = 3;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_W-1:0] OUT_WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] OUT_HEIGHT_RESET = CFG_W'(400);

	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = CFG_IDX_W'(1);

	// Three 6-bit quarter bytes of one source pixel.
	typedef struct packed {
		logic [5:0] q2;
		logic [5:0] q1;
		logic [5:0] q0;
	} quarters_t;

	// Three 7-bit sums of a horizontal pixel pair; one line buffer entry.
	typedef struct packed {
		logic [6:0] s2;
		logic [6:0] s1;
		logic [6:0] s0;
	} pair_sums_t;

	typedef struct packed {
		logic [15:0] plane0;
		logic [15:0] plane1;
		logic [15:0] plane2;
		logic [9:0]  out_x;
		logic [9:0]  out_y;
	} result_t;

	// Line buffer write and read requests issued in the accept cycle.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		pair_sums_t        wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	// Box sum of 0..252 scaled by 257, i.e. sum/255 in 0.16 fixed point.
	function automatic logic [15:0] scale_unit(input logic [7:0] sum);
		scale_unit = {sum, 8'd0} + {8'd0, sum};
	endfunction

	// Clamps a register value to 1..cap and doubles it.
	function automatic logic [DIM2_W-1:0] double_clamped(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] cap);
		logic [CFG_W-1:0] eff;
		if (v == '0) begin
			eff = CFG_W'(1);
		end else if (v > cap) begin
			eff = cap;
		end else begin
			eff = v;
		end
		double_clamped = {eff, 1'b0};
	endfunction

endpackage

@@ rtl/bdpn_line_mem.sv @@
// One-row store of pair sums from even source rows, synchronous read.
module bdpn_line_mem (
	input  logic                clk,
	input  bdpn_pkg::mem_req_t  req,
	output bdpn_pkg::pair_sums_t rd_data_q
);

	bdpn_pkg::pair_sums_t mem_q [bdpn_pkg::MAX_OUT_WIDTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

endmodule

@@ rtl/box_downscale_planar_normalizer.sv @@
// Top level of the 2x2 box downscaler with planar normalized output.
//
//   channel   signals                         direction  payload
//   px        px_valid / px_stall             in         byte0 byte1 byte2 frame_start
//   res       res_valid / res_stall           out        plane0 plane1 plane2 out_x out_y
//   cfg       cfg_valid / cfg_ready           in         cfg_index cfg_data
//
// One source pixel per cycle is taken while px_stall is low; a result leaves after the pixel that
// completes its block, passing through the registered line buffer read and then the output queue.
// The line buffer is written and read in the cycle a pixel is transferred.
// Reset clears counters, flags and the queue; the line buffer holds no reset state.
// A three-entry output queue keeps pixels flowing while res is stalled; px_stall rises
// only when that queue and the read stage together hold three results.
module box_downscale_planar_normalizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           px_valid,
	output logic                           px_stall,
	input  logic [7:0]                     byte0,
	input  logic [7:0]                     byte1,
	input  logic [7:0]                     byte2,
	input  logic                           frame_start,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [15:0]                    plane0,
	output logic [15:0]                    plane1,
	output logic [15:0]                    plane2,
	output logic [9:0]                     out_x,
	output logic [9:0]                     out_y,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bdpn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdpn_pkg::CFG_W-1:0]     cfg_data
);

	logic [bdpn_pkg::DIM2_W-1:0] w2_q;
	logic [bdpn_pkg::DIM2_W-1:0] h2_q;
	logic [bdpn_pkg::CFG_W-1:0]  col_q;
	logic [bdpn_pkg::DIM2_W-1:0] row_q;
	bdpn_pkg::quarters_t         left_q;

	logic                        accept;
	logic [bdpn_pkg::CFG_W-1:0]  col;
	logic [bdpn_pkg::DIM2_W-1:0] row;
	logic                        active;
	bdpn_pkg::quarters_t         cur;
	bdpn_pkg::pair_sums_t        pair;
	logic [9:0]                  ox;
	bdpn_pkg::mem_req_t          mem_req;
	bdpn_pkg::pair_sums_t        mem_rd;

	logic                        valid_s1;
	bdpn_pkg::pair_sums_t        pair_s1;
	logic [9:0]                  x_s1;
	logic [9:0]                  y_s1;
	bdpn_pkg::result_t           res_new;

	bdpn_pkg::result_t           queue_q [bdpn_pkg::QUEUE_DEPTH];
	logic [bdpn_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [bdpn_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [bdpn_pkg::QCNT_W-1:0] count_q;
	logic                        push;
	logic                        pop;
	logic [bdpn_pkg::QCNT_W:0]   in_flight;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w2_q <= bdpn_pkg::double_clamped(bdpn_pkg::OUT_WIDTH_RESET,
				bdpn_pkg::CFG_W'(bdpn_pkg::WIDTH_CAP));
			h2_q <= bdpn_pkg::double_clamped(bdpn_pkg::OUT_HEIGHT_RESET,
				bdpn_pkg::CFG_W'(bdpn_pkg::HEIGHT_CAP));
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bdpn_pkg::REG_OUT_WIDTH: begin
					w2_q <= bdpn_pkg::double_clamped(cfg_data,
						bdpn_pkg::CFG_W'(bdpn_pkg::WIDTH_CAP));
				end
				bdpn_pkg::REG_OUT_HEIGHT: begin
					h2_q <= bdpn_pkg::double_clamped(cfg_data,
						bdpn_pkg::CFG_W'(bdpn_pkg::HEIGHT_CAP));
				end
				default: begin
				end
			endcase
		end
	end

	assign accept = px_valid && !px_stall;
	assign col    = frame_start ? '0 : col_q;
	assign row    = frame_start ? '0 : row_q;
	assign active = (row < h2_q) && ({1'b0, col} < w2_q);
	assign ox     = col[10:1];
	assign cur    = '{q2: byte2[7:2], q1: byte1[7:2], q0: byte0[7:2]};
	assign pair   = '{s2: {1'b0, left_q.q2} + {1'b0, cur.q2},
		s1: {1'b0, left_q.q1} + {1'b0, cur.q1},
		s0: {1'b0, left_q.q0} + {1'b0, cur.q0}};

	// Even rows store the pair sum; odd rows fetch it for the block total.
	always_comb begin
		mem_req.wr_en   = accept && active && col[0] && !row[0];
		mem_req.wr_addr = bdpn_pkg::ADDR_W'(ox);
		mem_req.wr_data = pair;
		mem_req.rd_en   = accept && active && col[0] && row[0];
		mem_req.rd_addr = bdpn_pkg::ADDR_W'(ox);
	end

	bdpn_line_mem u_line_mem (
		.clk       (clk),
		.req       (mem_req),
		.rd_data_q (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (({1'b0, col} + bdpn_pkg::DIM2_W'(1)) >= w2_q) begin
				col_q <= '0;
				if (row < h2_q) begin
					row_q <= row + bdpn_pkg::DIM2_W'(1);
				end else begin
					row_q <= row;
				end
			end else begin
				col_q <= col + bdpn_pkg::CFG_W'(1);
				row_q <= row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (accept && active && !col[0]) begin
			left_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= mem_req.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			pair_s1 <= pair;
			x_s1    <= ox;
			y_s1    <= row[10:1];
		end
	end

	always_comb begin
		res_new.plane0 = bdpn_pkg::scale_unit({1'b0, pair_s1.s0} + {1'b0, mem_rd.s0});
		res_new.plane1 = bdpn_pkg::scale_unit({1'b0, pair_s1.s1} + {1'b0, mem_rd.s1});
		res_new.plane2 = bdpn_pkg::scale_unit({1'b0, pair_s1.s2} + {1'b0, mem_rd.s2});
		res_new.out_x  = x_s1;
		res_new.out_y  = y_s1;
	end

	// The read stage always drains into the queue; the stall keeps room for it.
	assign push      = valid_s1;
	assign pop       = res_valid && !res_stall;
	assign in_flight = {1'b0, count_q} + {{bdpn_pkg::QCNT_W{1'b0}}, valid_s1};
	assign px_stall  = in_flight >= (bdpn_pkg::QCNT_W + 1)'(bdpn_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bdpn_pkg::QPTR_W'(bdpn_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + bdpn_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bdpn_pkg::QPTR_W'(bdpn_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + bdpn_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bdpn_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bdpn_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= res_new;
		end
	end

	assign res_valid = count_q != '0;
	assign plane0    = queue_q[rd_ptr_q].plane0;
	assign plane1    = queue_q[rd_ptr_q].plane1;
	assign plane2    = queue_q[rd_ptr_q].plane2;
	assign out_x     = queue_q[rd_ptr_q].out_x;
	assign out_y     = queue_q[rd_ptr_q].out_y;

endmodule

@@ rtl/bdpn_checker.sv @@
// Port-level checker for the downscaler, bound to the top level.
`include "box_downscale_planar_normalizer_assert.svh"

module bdpn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        px_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [15:0] plane0,
	input logic [15:0] plane1,
	input logic [15:0] plane2,
	input logic [9:0]  out_x,
	input logic [9:0]  out_y,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	logic [67:0] res_payload;
	logic        planes_ok;

	assign res_payload = {plane0, plane1, plane2, out_x, out_y};
	// Four bytes shifted right by two sum to at most 252, times 257 gives 64764.
	assign planes_ok   = (plane0 <= 16'd64764) && (plane1 <= 16'd64764) &&
		(plane2 <= 16'd64764);

	// A held result stays offered until its transfer.
	`BDPN_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid)

	// A held result keeps its payload.
	`BDPN_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && res_stall, $stable(res_payload))

	// Input backpressure needs at least two queued results, so a result is waiting.
	`BDPN_ASSERT_NOW(a_stall_needs_result, clk, arst_n, px_stall, res_valid)

	// Configuration writes are never refused.
	`BDPN_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

	`BDPN_ASSERT_NOW(a_plane_range, clk, arst_n, res_valid, planes_ok)

endmodule

bind box_downscale_planar_normalizer bdpn_checker u_bdpn_checker (.*);

@@ dv/tb_box_downscale_planar_normalizer.sv @@
// Self-checking testbench of the 2x2 box downscaler with planar normalized output.
`timescale 1ns / 100ps

module tb_box_downscale_planar_normalizer;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	// Index with no register behind it; writes to it must change nothing.
	localparam logic [bdpn_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = bdpn_pkg::CFG_IDX_W'(3);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic px_valid = 1'b0;
	logic px_stall;
	logic [7:0] byte0 = '0;
	logic [7:0] byte1 = '0;
	logic [7:0] byte2 = '0;
	logic frame_start = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [15:0] plane0;
	logic [15:0] plane1;
	logic [15:0] plane2;
	logic [9:0] out_x;
	logic [9:0] out_y;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bdpn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bdpn_pkg::CFG_W-1:0] cfg_data = '0;

	box_downscale_planar_normalizer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.px_valid(px_valid),
		.px_stall(px_stall),
		.byte0(byte0),
		.byte1(byte1),
		.byte2(byte2),
		.frame_start(frame_start),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.plane0(plane0),
		.plane1(plane1),
		.plane2(plane2),
		.out_x(out_x),
		.out_y(out_y),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Predictor state: a copy of the downscaler's counters, line store and registers.
	logic [bdpn_pkg::CFG_W-1:0] width_reg = bdpn_pkg::OUT_WIDTH_RESET;
	logic [bdpn_pkg::CFG_W-1:0] height_reg = bdpn_pkg::OUT_HEIGHT_RESET;
	bdpn_pkg::quarters_t left_quarters = '0;
	bdpn_pkg::pair_sums_t line_sums [bdpn_pkg::MAX_OUT_WIDTH];
	int src_col = 0;
	int src_row = 0;

	bdpn_pkg::result_t pending_boxes [$];
	bdpn_pkg::result_t predicted_box;
	bdpn_pkg::result_t oldest_box;

	int pixels_sent = 0;
	int boxes_checked = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// Advances the predictor by one source pixel; returns 1 when a box completes.
	function automatic bit downscale_pixel(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic fs, output bdpn_pkg::result_t box);
		bdpn_pkg::quarters_t q;
		bdpn_pkg::pair_sums_t row_above;
		logic [6:0] s0, s1, s2;
		logic [7:0] t0, t1, t2;
		int eff_w, eff_h, w2, h2, ox;
		bit made;
		eff_w = width_reg;
		if (eff_w < 1) eff_w = 1;
		if (eff_w > bdpn_pkg::WIDTH_CAP) eff_w = bdpn_pkg::WIDTH_CAP;
		eff_h = height_reg;
		if (eff_h < 1) eff_h = 1;
		if (eff_h > bdpn_pkg::HEIGHT_CAP) eff_h = bdpn_pkg::HEIGHT_CAP;
		w2 = 2 * eff_w;
		h2 = 2 * eff_h;
		q.q0 = b0[7:2];
		q.q1 = b1[7:2];
		q.q2 = b2[7:2];
		made = 1'b0;
		box = '0;
		if (fs) begin
			src_col = 0;
			src_row = 0;
		end
		if (src_row < h2 && src_col < w2) begin
			ox = src_col >> 1;
			if (src_col % 2 == 0) begin
				left_quarters = q;
			end else begin
				s0 = left_quarters.q0 + q.q0;
				s1 = left_quarters.q1 + q.q1;
				s2 = left_quarters.q2 + q.q2;
				if (ox < bdpn_pkg::MAX_OUT_WIDTH) begin
					if (src_row % 2 == 0) begin
						line_sums[ox].s0 = s0;
						line_sums[ox].s1 = s1;
						line_sums[ox].s2 = s2;
					end else begin
						row_above = line_sums[ox];
						t0 = s0 + row_above.s0;
						t1 = s1 + row_above.s1;
						t2 = s2 + row_above.s2;
						box.plane0 = 16'(t0 * 257);
						box.plane1 = 16'(t1 * 257);
						box.plane2 = 16'(t2 * 257);
						box.out_x = 10'(ox);
						box.out_y = 10'(src_row >> 1);
						made = 1'b1;
					end
				end
			end
		end
		if (src_col + 1 >= w2) begin
			src_col = 0;
			if (src_row < h2) src_row++;
		end else begin
			src_col++;
		end
		return made;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Watches every transfer: register writes, accepted pixels and delivered boxes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bdpn_pkg::REG_OUT_WIDTH: width_reg = cfg_data;
					bdpn_pkg::REG_OUT_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (px_valid && !px_stall) begin
				if (downscale_pixel(byte0, byte1, byte2, frame_start, predicted_box))
					pending_boxes = {pending_boxes, predicted_box};
			end
			if (res_valid && !res_stall) begin
				if (pending_boxes.size() == 0) begin
					$error("unexpected result at out_x %0d out_y %0d", out_x, out_y);
					mismatch_count++;
				end else begin
					oldest_box = pending_boxes.pop_front();
					check_field("plane0", oldest_box.plane0, plane0);
					check_field("plane1", oldest_box.plane1, plane1);
					check_field("plane2", oldest_box.plane2, plane2);
					check_field("out_x", oldest_box.out_x, out_x);
					check_field("out_y", oldest_box.out_y, out_y);
					boxes_checked++;
				end
			end
		end
	end

	// Output back-pressure: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= hold_len;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic fs);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			px_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		px_valid <= 1'b1;
		byte0 <= b0;
		byte1 <= b1;
		byte2 <= b2;
		frame_start <= fs;
		do @(posedge clk); while (px_stall);
		pixels_sent++;
	endtask

	// Sends a frame of w x h output pixels plus extra trailing pixels, cut at stop_at if set.
	task automatic send_frame(input int w, input int h, input int extra, input int stop_at,
			input bit first_fs, input int noise_pct);
		int total;
		logic fs;
		total = 4 * w * h + extra;
		if (stop_at >= 0 && stop_at < total) total = stop_at;
		for (int i = 0; i < total; i++) begin
			if (i == 0) fs = first_fs;
			else fs = ($urandom_range(99) < noise_pct);
			send_pixel(pick_byte(), pick_byte(), pick_byte(), fs);
		end
	endtask

	// Stops sending and waits until every predicted box has been delivered.
	task automatic drain_results();
		px_valid <= 1'b0;
		@(posedge clk);
		while (pending_boxes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bdpn_pkg::CFG_IDX_W-1:0] idx,
			input logic [bdpn_pkg::CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_size(input int w, input int h, input bit poke_unused);
		drain_results();
		if (poke_unused) write_reg(CFG_IDX_UNUSED, bdpn_pkg::CFG_W'($urandom_range(2047)));
		write_reg(bdpn_pkg::REG_OUT_WIDTH, bdpn_pkg::CFG_W'(w));
		write_reg(bdpn_pkg::REG_OUT_HEIGHT, bdpn_pkg::CFG_W'(h));
		cfg_valid <= 1'b0;
	endtask

	task automatic test_extremes();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_size(1, 1, 1'b1);
		for (int i = 0; i < 4; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, i == 0);
		for (int i = 0; i < 4; i++) send_pixel(8'h00, 8'h00, 8'h00, i == 0);
	endtask

	// Zero registers clamp to a 1x1 output, so the third source row is dropped.
	task automatic test_dropped_rows();
		set_size(0, 0, 1'b0);
		send_frame(1, 1, 1, -1, 1'b1, 0);
	endtask

	// Narrowing mid-row leaves the column past the new row end; that pixel ends the row.
	task automatic test_column_beyond_row();
		set_size(2, 2, 1'b0);
		send_frame(2, 2, 0, 6, 1'b1, 0);
		set_size(1, 2, 1'b0);
		send_frame(2, 2, 0, 5, 1'b0, 0);
	endtask

	// The output holds off long enough for the block to fill and stall its pixel input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_size(2, 4, 1'b0);
		hold_len = 300;
		hold_requests++;
		send_frame(2, 4, 0, -1, 1'b1, 0);
		drain_results();
	endtask

	task automatic test_random_frames();
		int send_mix [4] = '{0, 85, 0, 21};
		int recv_mix [4] = '{0, 0, 85, 21};
		int w, h, eff_w, eff_h, kind, phase_base;
		for (int m = 0; m < 4; m++) begin
			send_idle_pct = send_mix[m];
			recv_stall_pct = recv_mix[m];
			phase_base = pixels_sent;
			while (pixels_sent - phase_base < 110) begin
				w = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 6);
				h = $urandom_range(0, 5);
				eff_w = (w == 0) ? 1 : w;
				eff_h = (h == 0) ? 1 : h;
				set_size(w, h, 1'b0);
				repeat ($urandom_range(1, 3)) begin
					kind = $urandom_range(9);
					if (kind < 7)
						send_frame(eff_w, eff_h, $urandom_range(0, 3), -1, 1'b1, 0);
					else if (kind < 9)
						send_frame(eff_w, eff_h, 0, $urandom_range(1, 4 * eff_w * eff_h),
							1'b1, 5);
					else
						drain_results();
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_dropped_rows();
		test_column_beyond_row();
		test_backpressure();
		test_random_frames();
		drain_results();
		repeat (16) @(posedge clk);
		$display("Sent %0d source pixels, checked %0d output boxes in %0d cycles.",
			pixels_sent, boxes_checked, cycle_count);
		$display("Sizes up to 6x5, zero registers, cut rows, four idle mixes, long hold-off.");
		if (mismatch_count == 0 && pending_boxes.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bdpn_pkg.sv
rtl/bdpn_line_mem.sv
rtl/box_downscale_planar_normalizer.sv
rtl/bdpn_checker.sv
dv/tb_box_downscale_planar_normalizer.sv
